### rtl/core/ctes_pkg.sv
package ctes_pkg;

	// Field widths of one input item and one result
	localparam int YearW   = 15;
	localparam int MonthW  = 4;
	localparam int DayW    = 5;
	localparam int HourW   = 5;
	localparam int MinuteW = 6;
	localparam int SecondW = 6;
	localparam int SecsW   = 40;

	// Packed bus widths, rounded up to whole bytes
	localparam int InFieldsW = YearW + MonthW + DayW + HourW + MinuteW + SecondW;
	localparam int InDataW   = ((InFieldsW + 7) / 8) * 8;
	localparam int OutDataW  = ((SecsW + 7) / 8) * 8;

	// Calendar constants
	localparam logic [3:0]  MonthMax    = 4'd11;
	localparam logic [15:0] EpochOffset = 16'd70;      // 1970 - 1900
	localparam logic [15:0] LeapOffset  = 16'd69;      // year before the epoch, 1969 - 1900
	localparam logic [23:0] DaysPerYear = 24'd365;
	localparam logic [16:0] SecsPerHour = 17'd3600;
	localparam logic [16:0] SecsPerMin  = 17'd60;
	localparam logic [40:0] SecsPerDay  = 41'd86400;

	// Bias the year into a positive range before dividing by 100 (164 centuries)
	localparam logic [15:0] YearBias = 16'd16400;
	localparam logic [9:0]  CentBias = 10'd164;
	localparam logic [15:0] Century  = 16'd100;

	// ceil(2^19 / 100): exact floor quotient for dividends below 43690
	localparam logic [27:0] Recip100   = 28'd5243;
	localparam int          Recip100Sh = 19;

	// One input item
	typedef struct packed {
		logic                 valid;
		logic [YearW-1:0]     year;
		logic [MonthW-1:0]    month;
		logic [DayW-1:0]      day;
		logic [HourW-1:0]     hour;
		logic [MinuteW-1:0]   minute;
		logic [SecondW-1:0]   second;
	} item_t;

	// Stage 1: month clamped, year biased for the century divide
	typedef struct packed {
		logic                 valid;
		logic [YearW-1:0]     year;
		logic [MonthW-1:0]    month;
		logic [DayW-1:0]      day;
		logic [HourW-1:0]     hour;
		logic [MinuteW-1:0]   minute;
		logic [SecondW-1:0]   second;
		logic [15:0]          ybias;
	} s1_t;

	// Stage 2: reciprocal product, year term, leap-day term, time of day
	typedef struct packed {
		logic                 valid;
		logic [1:0]           year_lo;
		logic [MonthW-1:0]    month;
		logic [DayW-1:0]      day;
		logic [15:0]          ybias;
		logic [27:0]          qprod;
		logic [23:0]          ydays;
		logic [13:0]          div4;
		logic [16:0]          tod;
	} s2_t;

	// Stage 3: day-count terms ready for the final sum
	typedef struct packed {
		logic                 valid;
		logic [23:0]          ydays;
		logic [13:0]          div4;
		logic [9:0]           div100;
		logic [7:0]           div400;
		logic [9:0]           yday;
		logic [16:0]          tod;
	} s3_t;

	// Stage 4: whole days since the epoch
	typedef struct packed {
		logic                 valid;
		logic [23:0]          days;
		logic [16:0]          tod;
	} s4_t;

	// Stage 5: days scaled to seconds
	typedef struct packed {
		logic                 valid;
		logic [40:0]          dsecs;
		logic [16:0]          tod;
	} s5_t;

	// Result
	typedef struct packed {
		logic                 valid;
		logic [SecsW-1:0]     secs;
	} res_t;

	// Days before the first of each month
	function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
		logic [8:0] base;
		unique case (month)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			default: base = 9'd334;
		endcase
		return base + {8'd0, (leap && (month >= 4'd2))};
	endfunction

endpackage

### rtl/core/ctes_front.sv
module ctes_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctes_pkg::item_t  item,
	output ctes_pkg::s2_t    out
);

	ctes_pkg::s1_t nxt_s1;
	ctes_pkg::s1_t st_s1;
	ctes_pkg::s2_t nxt_s2;
	ctes_pkg::s2_t st_s2;

	logic [15:0] yr_ext;
	logic [15:0] yr_m70;
	logic [15:0] yr_m69;
	logic [16:0] ybias_wide;

	// Clamp month, bias year so the century divide sees a positive value
	always_comb begin
		ybias_wide = {{2{item.year[14]}}, item.year} + {1'b0, ctes_pkg::YearBias};
		nxt_s1.valid  = item.valid;
		nxt_s1.year   = item.year;
		nxt_s1.month  = (item.month > ctes_pkg::MonthMax) ? ctes_pkg::MonthMax : item.month;
		nxt_s1.day    = item.day;
		nxt_s1.hour   = item.hour;
		nxt_s1.minute = item.minute;
		nxt_s1.second = item.second;
		nxt_s1.ybias  = ybias_wide[15:0];
	end

	// Reciprocal multiply for /100, whole-year days, leap-day count, time of day
	always_comb begin
		yr_ext = {st_s1.year[14], st_s1.year};
		yr_m70 = yr_ext - ctes_pkg::EpochOffset;
		yr_m69 = yr_ext - ctes_pkg::LeapOffset;
		nxt_s2.valid   = st_s1.valid;
		nxt_s2.year_lo = st_s1.year[1:0];
		nxt_s2.month   = st_s1.month;
		nxt_s2.day     = st_s1.day;
		nxt_s2.ybias   = st_s1.ybias;
		nxt_s2.qprod   = {12'd0, st_s1.ybias} * ctes_pkg::Recip100;
		nxt_s2.ydays   = {{8{yr_m70[15]}}, yr_m70} * ctes_pkg::DaysPerYear;
		nxt_s2.div4    = yr_m69[15:2];
		nxt_s2.tod     = {12'd0, st_s1.hour} * ctes_pkg::SecsPerHour
		               + {11'd0, st_s1.minute} * ctes_pkg::SecsPerMin
		               + {11'd0, st_s1.second};
	end

	// Advance both stages together on enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
			st_s2 <= '0;
		end else if (en) begin
			st_s1 <= nxt_s1;
			st_s2 <= nxt_s2;
		end
	end

	assign out = st_s2;

endmodule

### rtl/core/ctes_days.sv
module ctes_days (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  ctes_pkg::s2_t  in_st,
	output ctes_pkg::s4_t  out
);

	ctes_pkg::s3_t nxt_s3;
	ctes_pkg::s3_t st_s3;
	ctes_pkg::s4_t nxt_s4;
	ctes_pkg::s4_t st_s4;

	logic [8:0]  cent_q;
	logic        cent_exact;
	logic [9:0]  cent;
	logic [9:0]  quad;
	logic        leap;
	logic [8:0]  mdays;

	// Century quotient and remainder test give the /100, /400 terms and leap flag
	always_comb begin
		cent_q     = in_st.qprod[ctes_pkg::Recip100Sh +: 9];
		cent_exact = (in_st.ybias == ({7'd0, cent_q} * ctes_pkg::Century));
		cent       = {1'b0, cent_q} - ctes_pkg::CentBias;
		quad       = cent + 10'd3 - {9'd0, cent_exact};
		leap       = (in_st.year_lo == 2'b00) && (!cent_exact || (cent_q[1:0] == 2'b01));
		mdays      = ctes_pkg::days_before(in_st.month, leap);
		nxt_s3.valid  = in_st.valid;
		nxt_s3.ydays  = in_st.ydays;
		nxt_s3.div4   = in_st.div4;
		nxt_s3.div100 = cent - {9'd0, cent_exact};
		nxt_s3.div400 = quad[9:2];
		nxt_s3.yday   = {5'd0, in_st.day} - 10'd1 + {1'b0, mdays};
		nxt_s3.tod    = in_st.tod;
	end

	// Sum the day-count terms
	always_comb begin
		nxt_s4.valid = st_s3.valid;
		nxt_s4.days  = st_s3.ydays
		             + {{10{st_s3.div4[13]}}, st_s3.div4}
		             + {{14{st_s3.yday[9]}}, st_s3.yday}
		             - {{14{st_s3.div100[9]}}, st_s3.div100}
		             + {{16{st_s3.div400[7]}}, st_s3.div400};
		nxt_s4.tod   = st_s3.tod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s3 <= '0;
			st_s4 <= '0;
		end else if (en) begin
			st_s3 <= nxt_s3;
			st_s4 <= nxt_s4;
		end
	end

	assign out = st_s4;

endmodule

### rtl/core/ctes_scale.sv
module ctes_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  ctes_pkg::s4_t   in_st,
	output ctes_pkg::res_t  out
);

	ctes_pkg::s5_t  nxt_s5;
	ctes_pkg::s5_t  st_s5;
	ctes_pkg::res_t nxt_s6;
	ctes_pkg::res_t st_s6;
	logic [40:0]    total;

	// Scale days to seconds
	always_comb begin
		nxt_s5.valid = in_st.valid;
		nxt_s5.dsecs = {{17{in_st.days[23]}}, in_st.days} * ctes_pkg::SecsPerDay;
		nxt_s5.tod   = in_st.tod;
	end

	// Add the time of day and drop to the result width
	always_comb begin
		total        = st_s5.dsecs + {24'd0, st_s5.tod};
		nxt_s6.valid = st_s5.valid;
		nxt_s6.secs  = total[ctes_pkg::SecsW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s5 <= '0;
			st_s6 <= '0;
		end else if (en) begin
			st_s5 <= nxt_s5;
			st_s6 <= nxt_s6;
		end
	end

	assign out = st_s6;

endmodule

### rtl/core/civil_time_to_epoch_seconds_top.sv
// Pipeline: six register stages, st_s1 through st_s6; a transfer accepted at the input shows its
// result on m_tvalid after passing through all of them, when m_tready stays high.
// Throughput: one item per cycle; the whole pipeline holds while the output register is
// full and m_tready is low.
// Reset: arst_n clears every stage's valid bit at once; no clearing pass is needed.
module civil_time_to_epoch_seconds_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// year_since_1900[14:0], month_index[18:15], day_of_month[23:19],
	// hour_of_day[28:24], minute_of_hour[34:29], second_of_minute[40:35], zero[47:41]
	input  logic [ctes_pkg::InDataW-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// epoch_seconds[39:0]
	output logic [ctes_pkg::OutDataW-1:0] m_tdata
);

	ctes_pkg::item_t item;
	ctes_pkg::s2_t   front_st;
	ctes_pkg::s4_t   days_st;
	ctes_pkg::res_t  res;
	logic            en;

	// Advance the pipeline unless the output register holds an untaken result
	assign en       = !res.valid || m_tready;
	assign s_tready = en;

	// Unpack the input transfer
	always_comb begin
		item.valid  = s_tvalid;
		item.year   = s_tdata[14:0];
		item.month  = s_tdata[18:15];
		item.day    = s_tdata[23:19];
		item.hour   = s_tdata[28:24];
		item.minute = s_tdata[34:29];
		item.second = s_tdata[40:35];
	end

	ctes_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.item   (item),
		.out    (front_st)
	);

	ctes_days u_days (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_st  (front_st),
		.out    (days_st)
	);

	ctes_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_st  (days_st),
		.out    (res)
	);

	assign m_tvalid = res.valid;
	assign m_tdata  = res.secs;

endmodule

### rtl/core/ctes_checker.sv
module ctes_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [ctes_pkg::OutDataW-1:0] m_tdata
);

	// Input side is open exactly when the output register can move
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not track output register state");

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// With the output side open, an accepted item comes out after the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		##1 m_tready |=> m_tvalid)
		else $error("accepted item did not reach the output in time");

	// Reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result shown during reset");

endmodule

bind civil_time_to_epoch_seconds_top ctes_checker u_ctes_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/civil_time_to_epoch_seconds_top_tb.sv
module civil_time_to_epoch_seconds_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int InW  = ctes_pkg::InDataW;
	localparam int OutW = ctes_pkg::OutDataW;
	localparam int RandomItems = 1600;

	// Days before the first of each month
	localparam int CommonCum [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	localparam int LeapCum   [12] = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

	// One row of the directed table
	typedef struct {
		logic [14:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		bit          has_secs;
		logic [39:0] secs;
	} stim_row_t;

	localparam int DirectedRows = 22;

	stim_row_t directed_rows [DirectedRows] = '{
		// the epoch itself, one second before, well-known instants
		'{15'd70,   4'd0,  5'd1,  5'd0,  6'd0,  6'd0,  1'b1, 40'd0},
		'{15'd69,   4'd11, 5'd31, 5'd23, 6'd59, 6'd59, 1'b1, 40'hFF_FFFF_FFFF},
		'{15'd100,  4'd2,  5'd1,  5'd0,  6'd0,  6'd0,  1'b1, 40'd951868800},
		'{15'd138,  4'd0,  5'd19, 5'd3,  6'd14, 6'd8,  1'b1, 40'd2147483648},
		// leap rule: century years and year zero
		'{15'd100,  4'd1,  5'd29, 5'd12, 6'd0,  6'd0,  1'b0, 40'd0},
		'{15'd0,    4'd1,  5'd29, 5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		'{15'd0,    4'd2,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		'{15'h7894, 4'd2,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		'{15'h7893, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0, 40'd0},
		'{15'h7FFF, 4'd0,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		// nominal year extremes
		'{15'h5185, 4'd0,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		'{15'd8099, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60, 1'b0, 40'd0},
		// full field width of the year
		'{15'h4000, 4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		'{15'h3FFF, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0, 40'd0},
		// month above December saturates
		'{15'd120,  4'd12, 5'd1,  5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		'{15'd120,  4'd15, 5'd15, 5'd6,  6'd30, 6'd30, 1'b0, 40'd0},
		// day zero and day past the end of a short month
		'{15'd121,  4'd2,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		'{15'd123,  4'd1,  5'd31, 5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		// time of day beyond its range adds on linearly
		'{15'd90,   4'd5,  5'd10, 5'd31, 6'd0,  6'd0,  1'b0, 40'd0},
		'{15'd90,   4'd5,  5'd10, 5'd0,  6'd63, 6'd63, 1'b0, 40'd0},
		// all fields zero, all fields ones
		'{15'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0, 40'd0},
		'{15'h7FFF, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0, 40'd0}
	};

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [InW-1:0]  s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OutW-1:0] m_tdata;

	logic [39:0] pending_secs [$];
	int          mismatch_count = 0;
	bit          burst_mode = 1'b0;

	civil_time_to_epoch_seconds_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Floor division, rounding toward minus infinity
	function automatic longint floor_quot(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q -= 1;
		return q;
	endfunction

	// Seconds since the epoch for one packed time stamp
	function automatic logic [39:0] epoch_seconds_of(input logic [InW-1:0] item);
		longint     yr;
		longint     cal_year;
		longint     yday;
		longint     days;
		longint     secs;
		logic [3:0] mon;
		bit         leap;
		yr = longint'($signed(item[14:0]));
		mon = item[18:15];
		if (mon > ctes_pkg::MonthMax) mon = ctes_pkg::MonthMax;
		cal_year = yr + 1900;
		leap = ((cal_year % 4 == 0) && (cal_year % 100 != 0)) || (cal_year % 400 == 0);
		yday = longint'(item[23:19]) - 1 + (leap ? LeapCum[mon] : CommonCum[mon]);
		days = yday + (yr - 70) * 365 + floor_quot(yr - 69, 4) - floor_quot(yr - 1, 100)
			+ floor_quot(yr + 299, 400);
		secs = days * 86400 + longint'(item[28:24]) * 3600 + longint'(item[34:29]) * 60
			+ longint'(item[40:35]);
		return secs[39:0];
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drive one transfer, record its expected result, then idle unless burst mode is on
	task automatic send_item(input logic [InW-1:0] data, input logic [39:0] secs);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_secs.push_back(secs);
		gap = burst_mode ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		logic [39:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_secs.size() == 0) begin
				$display("%0t: unexpected result, got %0d", $time, $signed(m_tdata[39:0]));
				mismatch_count++;
			end else begin
				want = pending_secs.pop_front();
				if (m_tdata[39:0] !== want) begin
					$display("%0t: epoch_seconds mismatch: expected %0d, got %0d", $time,
						$signed(want), $signed(m_tdata[39:0]));
					mismatch_count++;
				end
			end
		end
	end

	// Receiver: alternate ready runs and stalls of random length, or stay ready in burst mode
	initial begin
		int  rx_left;
		bit  rx_ready;
		rx_left = 0;
		rx_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (burst_mode) begin
				m_tready <= 1'b1;
			end else begin
				if (rx_left <= 0) begin
					rx_ready = !rx_ready;
					rx_left = rx_ready ? $urandom_range(1, 12) : idle_len() + 1;
				end
				rx_left--;
				m_tready <= rx_ready;
			end
		end
	end

	// Main stimulus
	initial begin
		logic [InW-1:0] item;
		logic [14:0]    year;
		logic [3:0]     month;
		logic [4:0]     day;
		logic [4:0]     hour;
		logic [5:0]     minute;
		logic [5:0]     second;
		int             r;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i]) begin
			item = {7'd0, directed_rows[i].second, directed_rows[i].minute,
				directed_rows[i].hour, directed_rows[i].day, directed_rows[i].month,
				directed_rows[i].year};
			send_item(item, directed_rows[i].has_secs ? directed_rows[i].secs
				: epoch_seconds_of(item));
		end

		// Random time stamps, mostly in range, some with raw field values
		for (int i = 0; i < RandomItems; i++) begin
			// back-to-back stretches with no idling on either side
			if (i % 400 == 200) burst_mode = 1'b1;
			if (i % 400 == 300) burst_mode = 1'b0;

			// hold off until the pipeline has drained
			if (i == 800) begin
				s_tvalid <= 1'b0;
				while (pending_secs.size() != 0) @(posedge clk);
			end

			r = $urandom_range(0, 99);
			if (r < 60) year = 15'($urandom_range(0, 19998) - 11899);
			else if (r < 80) year = 15'($urandom_range(40, 140));
			else year = 15'($urandom);
			month  = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 11)) : 4'($urandom);
			day    = ($urandom_range(0, 99) < 88) ? 5'($urandom_range(1, 31)) : 5'($urandom);
			hour   = ($urandom_range(0, 99) < 88) ? 5'($urandom_range(0, 23)) : 5'($urandom);
			minute = ($urandom_range(0, 99) < 88) ? 6'($urandom_range(0, 59)) : 6'($urandom);
			second = ($urandom_range(0, 99) < 88) ? 6'($urandom_range(0, 60)) : 6'($urandom);
			item = {7'd0, second, minute, hour, day, month, year};
			send_item(item, epoch_seconds_of(item));
		end

		// Drain, then allow the pipeline latency to pass
		s_tvalid <= 1'b0;
		burst_mode = 1'b0;
		while (pending_secs.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(20_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
